// ===== hw/rtl/perm_unrk_pkg.sv =====
// Package for the factoradic permutation unranking block.
// Holds the field widths, the pipeline sizing and the stage payload types.
// Depends on nothing; imported by permutation_unrank_factoradic and its testbench.
package perm_unrk_pkg;

  localparam int MAX_DIMS    = 9;
  localparam int SIZE_W      = 4;
  localparam int RANK_W      = 19;
  localparam int SEQ_W       = 36;
  localparam int NIB_W       = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int FIRST_BASE  = 2;
  localparam int NDIV        = MAX_DIMS - 1;
  localparam int DIG_W       = $clog2(MAX_DIMS);
  localparam int MUL_W       = RANK_W + 2;
  localparam int PROD_W      = RANK_W + MUL_W;

  typedef logic [NDIV-1:0][DIG_W-1:0]     dig_t;
  typedef logic [MAX_DIMS-1:0][NIB_W-1:0] pool_t;

endpackage

// ===== hw/rtl/permutation_unrank_factoradic.sv =====
// Factoradic permutation unranking: rank and size in, packed index sequence out.
// A constant-divide pipeline produces the Lehmer digits, a selection pipeline
// picks one pool entry per position. Depends on perm_unrk_pkg.
//
// Usage: each input beat on s_axis carries perm_size (bits 3:0) and rank
// (bits 22:4). Each input beat gives exactly one output beat on m_axis whose
// tdata holds the chosen index per position, four bits each, position 0 lowest.
// Sizes above nine saturate to nine; ranks wrap modulo the size factorial.
// The pipeline is 18 register stages deep. Eight stages divide the rank by
// the bases two to nine, one reciprocal multiply each, a ninth takes the last
// remainder, and nine stages each resolve one position of the permutation.
// One beat is taken every cycle while the output side keeps up. When the
// receiver stalls, each stage holds its beat only while the stage after it is
// full, so bubbles close up and s_axis_tready falls only once every stage
// holds a beat.
// Reset clears the valid bit of every stage; no clearing pass is needed and
// the block accepts a beat in the first cycle after reset is released.
module permutation_unrank_factoradic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // perm_size [3:0], rank [22:4], zero [23]
  input  logic [perm_unrk_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // sequence_packed [35:0], zero [39:36]
  output logic [perm_unrk_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import perm_unrk_pkg::*;

  logic [SIZE_W-1:0] in_size;
  logic [SIZE_W-1:0] n_sat;
  logic [RANK_W-1:0] in_rank;

  logic [NDIV:0]     dv_vld_q;
  logic [NDIV:0]     dv_rdy;
  logic [SIZE_W-1:0] dv_n_q   [NDIV+1];
  logic [RANK_W-1:0] dv_x_q   [NDIV+1];
  logic [RANK_W-1:0] dv_quo_q [NDIV+1];
  dig_t              dv_dig_q [NDIV+1];

  logic [MAX_DIMS-1:0] sl_vld_q;
  logic [MAX_DIMS-1:0] sl_rdy;
  logic [SIZE_W-1:0]   sl_n_q    [MAX_DIMS];
  dig_t                sl_dig_q  [MAX_DIMS];
  pool_t               sl_pool_q [MAX_DIMS];
  pool_t               sl_acc_q  [MAX_DIMS];

  assign in_size = s_axis_tdata[SIZE_W-1:0];
  assign in_rank = s_axis_tdata[SIZE_W +: RANK_W];
  assign n_sat   = (in_size > SIZE_W'(MAX_DIMS)) ? SIZE_W'(MAX_DIMS) : in_size;

  assign s_axis_tready = dv_rdy[0];

  for (genvar k = 0; k <= NDIV; k++) begin : g_div
    logic              vld_in;
    logic              rdy_nxt;
    logic [SIZE_W-1:0] n_in;
    logic [RANK_W-1:0] src;
    logic [RANK_W-1:0] quo_d;
    dig_t              dig_d;

    if (k == 0) begin : g_first
      assign vld_in = s_axis_tvalid;
      assign n_in   = n_sat;
      assign src    = in_rank;
      assign dig_d  = '0;
    end else begin : g_next
      logic [RANK_W-1:0] rem;
      assign vld_in = dv_vld_q[k-1];
      assign n_in   = dv_n_q[k-1];
      assign src    = dv_quo_q[k-1];
      assign rem    = dv_x_q[k-1] - RANK_W'(dv_quo_q[k-1] * RANK_W'(k - 1 + FIRST_BASE));
      always_comb begin
        dig_d      = dv_dig_q[k-1];
        dig_d[k-1] = DIG_W'(rem);
      end
    end

    if (k < NDIV) begin : g_mul
      localparam int B  = k + FIRST_BASE;
      localparam int SH = RANK_W + $clog2(B);
      localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((64'd1 << SH) + 64'(B) - 64'd1) / 64'(B));
      logic [PROD_W-1:0] prod;
      assign prod  = PROD_W'(src) * PROD_W'(RECIP);
      assign quo_d = RANK_W'(prod >> SH);
      assign rdy_nxt = dv_rdy[k+1];
    end else begin : g_last
      assign quo_d   = '0;
      assign rdy_nxt = sl_rdy[0];
    end

    assign dv_rdy[k] = !dv_vld_q[k] || rdy_nxt;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (dv_rdy[k]) begin
        dv_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (dv_rdy[k] && vld_in) begin
        dv_n_q[k]   <= n_in;
        dv_x_q[k]   <= src;
        dv_quo_q[k] <= quo_d;
        dv_dig_q[k] <= dig_d;
      end
    end
  end

  for (genvar p = 0; p < MAX_DIMS; p++) begin : g_sel
    logic              vld_in;
    logic              rdy_nxt;
    logic [SIZE_W-1:0] n_in;
    dig_t              dig_in;
    pool_t             pool_in;
    pool_t             acc_in;
    logic [DIG_W-1:0]  d;
    logic [NIB_W-1:0]  chosen;
    pool_t             pool_d;
    pool_t             acc_d;

    if (p == 0) begin : g_first
      assign vld_in = dv_vld_q[NDIV];
      assign n_in   = dv_n_q[NDIV];
      assign dig_in = dv_dig_q[NDIV];
      assign acc_in = '0;
      always_comb begin
        for (int k = 0; k < MAX_DIMS; k++) begin
          pool_in[k] = NIB_W'(k);
        end
      end
    end else begin : g_next
      assign vld_in  = sl_vld_q[p-1];
      assign n_in    = sl_n_q[p-1];
      assign dig_in  = sl_dig_q[p-1];
      assign pool_in = sl_pool_q[p-1];
      assign acc_in  = sl_acc_q[p-1];
    end

    if (p == MAX_DIMS - 1) begin : g_out
      assign rdy_nxt = m_axis_tready;
    end else begin : g_mid
      assign rdy_nxt = sl_rdy[p+1];
    end

    always_comb begin
      d = '0;
      for (int k = 0; k < NDIV; k++) begin
        if (int'(n_in) == k + FIRST_BASE + p) begin
          d = dig_in[k];
        end
      end
      chosen = '0;
      for (int k = 0; k < MAX_DIMS; k++) begin
        if (int'(d) == k) begin
          chosen = pool_in[k];
        end
      end
      for (int k = 0; k < MAX_DIMS - 1; k++) begin
        pool_d[k] = (k < int'(d)) ? pool_in[k] : pool_in[k+1];
      end
      pool_d[MAX_DIMS-1] = '0;
      acc_d = acc_in;
      if (p < int'(n_in)) begin
        acc_d[p] = chosen;
      end
    end

    assign sl_rdy[p] = !sl_vld_q[p] || rdy_nxt;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sl_vld_q[p] <= 1'b0;
      end else if (sl_rdy[p]) begin
        sl_vld_q[p] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (sl_rdy[p] && vld_in) begin
        sl_n_q[p]    <= n_in;
        sl_dig_q[p]  <= dig_in;
        sl_pool_q[p] <= pool_d;
        sl_acc_q[p]  <= acc_d;
      end
    end
  end

  assign m_axis_tvalid = sl_vld_q[MAX_DIMS-1];
  assign m_axis_tdata  = OUT_TDATA_W'(sl_acc_q[MAX_DIMS-1]);

`ifndef SYNTHESIS
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sl_vld_q[MAX_DIMS-1] |-> s_axis_tready)
    else $error("input stalled although the final stage is empty");

  for (genvar k = 0; k < NDIV; k++) begin : g_chk_div
    a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      dv_vld_q[k] && !dv_rdy[k] |=> dv_vld_q[k] && $stable(dv_quo_q[k]))
      else $error("divide stage lost or changed a stalled beat");

    a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      dv_vld_q[NDIV] |-> int'(dv_dig_q[NDIV][k]) <= k + 1)
      else $error("factoradic digit exceeds its base");
  end

  a_small_size_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && sl_n_q[MAX_DIMS-1] <= SIZE_W'(1) |-> m_axis_tdata == '0)
    else $error("size of one or less must give an all-zero sequence");
`endif

endmodule

// ===== verif/permutation_unrank_factoradic_tb.sv =====
// Self-checking testbench for the factoradic permutation unranking block.
// A clocked driver and monitor move stream beats and compare every result with
// a local Lehmer-code predictor. Depends on perm_unrk_pkg and the block itself.
module permutation_unrank_factoradic_tb;
  import perm_unrk_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 100;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [RANK_W-1:0] rank;
  } unrank_req_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  unrank_req_t       unrank_req_q[$];
  logic [SEQ_W-1:0]  seq_exp_q[$];
  int                tx_idle_pct   = 0;
  int                rx_stall_pct  = 0;
  int                rx_hold_reqs  = 0;
  int                rx_hold_done  = 0;
  int                rx_hold_cnt   = 0;
  int                quiet_cycles  = 0;
  int                mismatches    = 0;

  permutation_unrank_factoradic dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [SEQ_W-1:0] unrank_lehmer(logic [SIZE_W-1:0] size,
                                                     logic [RANK_W-1:0] rank);
    int unsigned n, r, base, left, d, chosen;
    int unsigned digit[MAX_DIMS];
    int unsigned pool[MAX_DIMS];
    int          i, k;
    logic [SEQ_W-1:0] seq;
    n = size;
    if (n > MAX_DIMS) n = MAX_DIMS;
    r = rank;
    seq = '0;
    for (i = 0; i < MAX_DIMS; i++) begin
      digit[i] = 0;
      pool[i]  = i;
    end
    base = FIRST_BASE;
    for (i = 0; i + 1 < n; i++) begin
      digit[n - 2 - i] = r % base;
      r = r / base;
      base++;
    end
    left = n;
    for (i = 0; i < n; i++) begin
      d = digit[i];
      if (d >= left) d = left - 1;
      chosen = pool[d];
      for (k = d; k + 1 < left; k++) pool[k] = pool[k + 1];
      left--;
      seq[NIB_W*i +: NIB_W] = 4'(chosen);
    end
    return seq;
  endfunction

  function automatic int unsigned size_factorial(int unsigned size);
    int unsigned n, f, j;
    n = (size > MAX_DIMS) ? MAX_DIMS : size;
    f = 1;
    for (j = 2; j <= n; j++) f = f * j;
    return f;
  endfunction

  task automatic queue_request(int unsigned size, int unsigned rank);
    unrank_req_t req;
    req.size = SIZE_W'(size);
    req.rank = RANK_W'(rank);
    unrank_req_q.push_back(req);
  endtask

  task automatic queue_random(int count);
    int unsigned size, fact, rank, pick;
    repeat (count) begin
      if ($urandom_range(0, 99) < 85) size = $urandom_range(1, MAX_DIMS);
      else if ($urandom_range(0, 3) == 0) size = 0;
      else size = $urandom_range(MAX_DIMS + 1, (1 << SIZE_W) - 1);
      fact = size_factorial(size);
      pick = $urandom_range(0, 99);
      if (pick < 50) rank = $urandom_range(0, fact - 1);
      else if (pick < 85) rank = $urandom_range(0, (1 << RANK_W) - 1);
      else begin
        case ($urandom_range(0, 3))
          0: rank = 0;
          1: rank = fact - 1;
          2: rank = fact;
          default: rank = (1 << RANK_W) - 1;
        endcase
      end
      queue_request(size, rank);
    end
  endtask

  task automatic wait_drained();
    while (unrank_req_q.size() != 0 || seq_exp_q.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        seq_exp_q.push_back(unrank_lehmer(s_axis_tdata[SIZE_W-1:0],
                                          s_axis_tdata[SIZE_W +: RANK_W]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (unrank_req_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          unrank_req_t req;
          req = unrank_req_q.pop_front();
          s_axis_tdata  <= {1'b0, req.rank, req.size};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold_cnt   <= 0;
      rx_hold_done  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (seq_exp_q.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, actual %h", $time,
                   m_axis_tdata);
          mismatches++;
        end else begin
          logic [SEQ_W-1:0] seq_exp;
          seq_exp = seq_exp_q.pop_front();
          if (m_axis_tdata !== {{(OUT_TDATA_W-SEQ_W){1'b0}}, seq_exp}) begin
            $display("%0t: sequence mismatch, expected %h, actual %h", $time,
                     {{(OUT_TDATA_W-SEQ_W){1'b0}}, seq_exp}, m_axis_tdata);
            mismatches++;
          end
        end
      end
      if (rx_hold_reqs != rx_hold_done) begin
        rx_hold_done  <= rx_hold_reqs;
        rx_hold_cnt   <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_cnt > 0) begin
        rx_hold_cnt   <= rx_hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats: empty and trivial sizes, saturation, factorial edges.
    queue_request(0, 0);
    queue_request(0, 'h7FFFF);
    queue_request(1, 0);
    queue_request(1, 'h7FFFF);
    queue_request(2, 0);
    queue_request(2, 1);
    queue_request(2, 2);
    queue_request(3, 5);
    queue_request(3, 6);
    queue_request(4, 23);
    queue_request(5, 119);
    queue_request(6, 720);
    queue_request(7, 5039);
    queue_request(8, 40319);
    queue_request(8, 40320);
    queue_request(9, 0);
    queue_request(9, 362879);
    queue_request(9, 362880);
    queue_request(9, 'h7FFFF);
    queue_request(10, 12345);
    queue_request(12, 'h55555);
    queue_request(15, 'h7FFFF);
    queue_request(15, 'h2AAAA);
    queue_request(4, 'h7FFFF);
    queue_request(7, 'h40000);
    queue_random(60);
    wait_drained();
    queue_random(60);
    wait_drained();

    tx_idle_pct  = 46;
    rx_stall_pct = 0;
    queue_random(150);
    wait_drained();

    tx_idle_pct  = 0;
    rx_stall_pct = 46;
    queue_random(150);
    wait_drained();

    tx_idle_pct  = 15;
    rx_stall_pct = 15;
    queue_random(150);
    wait_drained();

    // The receiver holds off long enough for the pipeline to fill and back up.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    queue_random(80);
    rx_hold_reqs = rx_hold_reqs + 1;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/perm_unrk_pkg.sv
hw/rtl/permutation_unrank_factoradic.sv
verif/permutation_unrank_factoradic_tb.sv
